// ----- rtl/core/planar_to_packed_pixel_converter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the planar to packed pixel converter.
// The clock and reset names of the asserting module are clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TO_PACKED_PIXEL_CONVERTER_MACROS_SVH
`define PLANAR_TO_PACKED_PIXEL_CONVERTER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define P2P_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition is never true outside reset.
`define P2P_NEVER(label, cond, msg) \
    `P2P_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/core/p2p_pkg.sv -----
// ----------------------------------------------------------------------------
// p2p_pkg
// Types and constants shared by the planar to packed pixel converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2p_pkg;

    // Planes held in the row memory; the last plane is streamed straight in.
    localparam int STORED_PLANES = 3;
    localparam int NUM_PLANES    = 4;
    localparam logic [1:0] LAST_PLANE = 2'd3;

    // Packed bytes produced by one byte of the last plane.
    localparam int BURST_LEN = 4;
    localparam int BEAT_W    = $clog2(BURST_LEN);
    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(BURST_LEN - 1);

    localparam logic [7:0] ROW_LEN_RESET = 8'd105;

    typedef logic [7:0] byte_t;
    typedef logic [NUM_PLANES-1:0][7:0] plane_set_t;
    typedef logic [BURST_LEN-1:0][7:0] burst_t;

endpackage

`default_nettype wire

// ----- rtl/core/p2p_ram.sv -----
// ----------------------------------------------------------------------------
// p2p_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/planar_to_packed_pixel_converter.sv -----
// A last-plane byte goes through the read stage register and then the output burst register.
// Throughput: bytes of planes 0 to 2 are taken one per cycle; a byte of plane 3 yields four
// packed bytes, one per cycle while the output is ready; the output port sets the plane 3 byte rate.
// Reset clears the position and plane counters and the valid flags and sets the row length
// to 105; the row memory is not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
// planar_to_packed_pixel_converter
// Converts a pixel row given plane by plane into packed 4-bit pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "planar_to_packed_pixel_converter_macros.svh"

module planar_to_packed_pixel_converter
    import p2p_pkg::*;
#(
    parameter int MAX_PLANE_BYTES = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Row length register
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    // Input stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] plane_byte
    // Output stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] packed_pixels
    output logic            m_axis_tlast,   // last_of_burst
    output logic            m_axis_tuser    // [0] end_of_row
);

    localparam int POS_W = (MAX_PLANE_BYTES > 1) ? $clog2(MAX_PLANE_BYTES) : 1;
    localparam int CMP_W = ((POS_W > 8) ? POS_W : 8) + 2;

    // Control and configuration state
    logic [7:0]        row_len_reg;
    logic [POS_W-1:0]  byte_position_reg;
    logic [POS_W-1:0]  byte_position_next;
    logic [1:0]        plane_number_reg;
    logic [1:0]        plane_number_next;

    // Stage holding a plane 3 byte while the stored planes are read
    logic              s1_valid_reg;
    byte_t             s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_adv;

    // Output burst register
    logic              burst_valid_reg;
    logic [BEAT_W-1:0] beat_reg;
    burst_t            burst_reg;
    burst_t            burst_next;
    logic              eor_reg;

    logic              s_accept;
    logic              m_accept;
    logic              is_last;
    logic              is_last_plane;
    logic [CMP_W-1:0]  len_eff;
    logic [CMP_W-1:0]  cfg_ext;
    plane_set_t        plane_bytes;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = m_axis_tvalid && m_axis_tready;
    assign is_last_plane = (plane_number_reg == LAST_PLANE);

    // A zero length acts as one and a length above the memory acts as its size.
    always_comb
    begin
        cfg_ext = CMP_W'(row_len_reg);
        if (cfg_ext == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_PLANE_BYTES))
        begin
            len_eff = CMP_W'(MAX_PLANE_BYTES);
        end
        else
        begin
            len_eff = cfg_ext;
        end
    end

    assign is_last = ((CMP_W'(byte_position_reg) + CMP_W'(1)) >= len_eff);

    always_comb
    begin
        if (is_last)
        begin
            byte_position_next = '0;
            plane_number_next  = plane_number_reg + 2'd1;
        end
        else
        begin
            byte_position_next = byte_position_reg + POS_W'(1);
            plane_number_next  = plane_number_reg;
        end
    end

    // A held plane 3 byte advances if the burst register is free or its last beat leaves in this cycle.
    assign s1_adv = s1_valid_reg &&
                    (!burst_valid_reg || (m_accept && (beat_reg == LAST_BEAT)));

    // Bytes of the stored planes never enter the stage, so they pass even when it stalls.
    assign s_axis_tready = !is_last_plane || !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg <= ROW_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            row_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            plane_number_reg  <= '0;
        end
        else if (s_accept)
        begin
            byte_position_reg <= byte_position_next;
            plane_number_reg  <= plane_number_next;
        end
    end

    // Row memory: one RAM per stored plane, all read at the same position.
    for (genvar g = 0; g < STORED_PLANES; g++)
    begin : g_plane_ram
        p2p_ram #(
            .WIDTH (8),
            .DEPTH (MAX_PLANE_BYTES)
        ) u_ram (
            .clk     (clk),
            .wr_en   (s_accept && (plane_number_reg == 2'(g))),
            .wr_addr (byte_position_reg),
            .wr_data (s_axis_tdata),
            .rd_en   (s_accept && is_last_plane),
            .rd_addr (byte_position_reg),
            .rd_data (plane_bytes[g])
        );
    end

    assign plane_bytes[LAST_PLANE] = s1_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept && is_last_plane)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && is_last_plane)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= is_last;
        end
    end

    // Packed byte k holds pixels 2k (high nibble) and 2k+1; bit j of a pixel is plane j.
    always_comb
    begin
        for (int k = 0; k < BURST_LEN; k++)
        begin
            for (int j = 0; j < NUM_PLANES; j++)
            begin
                burst_next[k][4 + j] = plane_bytes[j][7 - 2 * k];
                burst_next[k][j]     = plane_bytes[j][6 - 2 * k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            beat_reg        <= '0;
        end
        else if (s1_adv)
        begin
            burst_valid_reg <= 1'b1;
            beat_reg        <= '0;
        end
        else if (m_accept)
        begin
            if (beat_reg == LAST_BEAT)
            begin
                burst_valid_reg <= 1'b0;
            end
            beat_reg <= beat_reg + BEAT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            burst_reg <= burst_next;
            eor_reg   <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = burst_valid_reg;
    assign m_axis_tdata  = burst_reg[beat_reg];
    assign m_axis_tlast  = (beat_reg == LAST_BEAT);
    assign m_axis_tuser  = eor_reg && (beat_reg == LAST_BEAT);

    `P2P_ASSERT(a_plane3_enters_stage,
        (s_accept && is_last_plane) |=> s1_valid_reg,
        "plane 3 byte did not reach the read stage")
    `P2P_ASSERT(a_burst_drains,
        (m_accept && m_axis_tlast && !s1_adv) |=> !m_axis_tvalid,
        "burst still valid after its last transfer")
    `P2P_ASSERT(a_beat_holds_on_stall,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(beat_reg)),
        "beat moved while the output stalled")
    `P2P_NEVER(a_row_end_mid_burst,
        m_axis_tvalid && m_axis_tuser && !m_axis_tlast,
        "end of row flagged before the last beat of a burst")
    `P2P_NEVER(a_stage_overrun,
        s1_valid_reg && !s1_adv && s_accept && is_last_plane,
        "plane 3 byte taken while the read stage is full")

endmodule

`default_nettype wire
